FILE: hdl/dra_pkg.sv
package dra_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_PACKET_BYTES     = 512;
    localparam int DEF_MAX_POINTER_HOPS = 32;

    // Parse offsets are 17 bits wide and saturate at their top value.
    localparam int OFFSET_W = 17;
    typedef logic [OFFSET_W-1:0] offset_t;
    localparam offset_t OFFSET_MAX = '1;

    localparam int COUNT_W = 16;
    typedef logic [COUNT_W-1:0] count_t;

    // DNS layout constants.
    localparam int HDR_BYTES   = 12;
    localparam int FIX_BYTES   = 10;
    localparam int QTAIL_BYTES = 4;
    localparam offset_t HDR_QD_HI = offset_t'(4);
    localparam offset_t HDR_QD_LO = offset_t'(5);
    localparam offset_t HDR_AN_HI = offset_t'(6);
    localparam offset_t HDR_AN_LO = offset_t'(7);
    localparam offset_t FIX_TYPE_HI  = offset_t'(0);
    localparam offset_t FIX_TYPE_LO  = offset_t'(1);
    localparam offset_t FIX_RDLEN_HI = offset_t'(8);
    localparam offset_t FIX_RDLEN_LO = offset_t'(9);
    localparam logic [7:0] PTR_MASK = 8'hC0;
    localparam count_t TYPE_A  = count_t'(1);
    localparam count_t A_RDLEN = count_t'(4);
    localparam int A_BYTES = 4;

    // Result handed from the parse sequencer to the output register.
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] address;
    } walk_result_t;

    function automatic offset_t sat_add(offset_t a, count_t b);
        logic [OFFSET_W:0] sum;
        sum = {1'b0, a} + {{(OFFSET_W + 1 - COUNT_W){1'b0}}, b};
        return (sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : sum[OFFSET_W-1:0];
    endfunction

endpackage

FILE: hdl/dns_response_a_record_extract.sv
// Channel   Direction  Handshake           Word contents
// input     in         in_valid, in_stall  data_byte, last_byte
// output    out        out_valid, out_stall address, found
//
// Each packet byte, up to PACKET_BYTES of them, is written into the packet
// memory, so bytes stream in at one word per cycle while in_stall is low. The
// word marked last_byte starts the parse; in_stall is then high until the
// result has moved into the output register. The parse is paced by the single
// read port of the packet memory, whose data returns in the cycle after the
// address. It reads the header counts, then walks each question and answer
// name label by label, following compression pointers, reads each answer
// fixed part and then the address bytes, and hands over the result.
// Reset clears the byte count, the sequencer and the output valid; no memory
// clearing pass is needed. A stalled result holds while the next packet loads.
module dns_response_a_record_extract #(
    parameter int PACKET_BYTES     = dra_pkg::DEF_PACKET_BYTES,
    parameter int MAX_POINTER_HOPS = dra_pkg::DEF_MAX_POINTER_HOPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] address,
    output logic        found
);
    import dra_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int LW = $clog2(PACKET_BYTES + 1);

    // Load side: the byte count doubles as the write pointer.
    logic [LW-1:0] count_reg, count_next;
    logic          in_accept;
    logic          has_room;
    logic          wr_en;
    logic [LW-1:0] start_len;

    // Parse sequencer and its memory read port.
    logic          walk_busy;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_q;
    walk_result_t  res;
    logic          res_ready;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   address_reg;
    logic          found_reg;
    logic          out_load;

    // The sequencer owns the memory while it runs, so loading stalls.
    assign in_stall  = walk_busy;
    assign in_accept = in_valid && !in_stall;
    assign has_room  = (count_reg < LW'(PACKET_BYTES));
    assign wr_en     = in_accept && has_room;

    // The last word is counted before the parse sees the length.
    assign start_len = has_room ? (count_reg + LW'(1)) : count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (in_accept)
        begin
            if (last_byte)
            begin
                count_next = '0;
            end
            else if (has_room)
            begin
                count_next = count_reg + LW'(1);
            end
        end
    end

    dra_mem #(
        .DEPTH (PACKET_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_q)
    );

    dra_walk #(
        .PACKET_BYTES     (PACKET_BYTES),
        .MAX_POINTER_HOPS (MAX_POINTER_HOPS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept && last_byte),
        .start_len (start_len),
        .busy      (walk_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_q      (rd_q),
        .res_ready (res_ready),
        .res       (res)
    );

    // A finished result moves out when the output register is empty or
    // is being emptied in this cycle.
    assign res_ready = !out_valid_reg || !out_stall;
    assign out_load  = res.valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            address_reg <= res.address;
            found_reg   <= res.found;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign found     = found_reg;

endmodule

FILE: hdl/dra_mem.sv
module dra_mem #(
    parameter int DEPTH = dra_pkg::DEF_PACKET_BYTES,
    parameter int AW    = $clog2(dra_pkg::DEF_PACKET_BYTES)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/dra_walk.sv
module dra_walk #(
    parameter int PACKET_BYTES     = dra_pkg::DEF_PACKET_BYTES,
    parameter int MAX_POINTER_HOPS = dra_pkg::DEF_MAX_POINTER_HOPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(PACKET_BYTES+1)-1:0]   start_len,
    output logic                                busy,
    output logic                                rd_en,
    output logic [$clog2(PACKET_BYTES)-1:0]     rd_addr,
    input  logic [7:0]                          rd_q,
    input  logic                                res_ready,
    output dra_pkg::walk_result_t               res
);
    import dra_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int LW = $clog2(PACKET_BYTES + 1);
    localparam int HW = $clog2(MAX_POINTER_HOPS + 1);

    typedef enum logic [9:0] {
        W_IDLE = 10'b00_0000_0001,
        W_HDR  = 10'b00_0000_0010,
        W_REC  = 10'b00_0000_0100,
        W_NAME = 10'b00_0000_1000,
        W_NDEC = 10'b00_0001_0000,
        W_PTR  = 10'b00_0010_0000,
        W_NEND = 10'b00_0100_0000,
        W_FIX  = 10'b00_1000_0000,
        W_DATA = 10'b01_0000_0000,
        W_DONE = 10'b10_0000_0000
    } walk_state_t;

    walk_state_t     state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    offset_t         offset_reg, offset_next;
    offset_t         pos_reg, pos_next;
    offset_t         end_reg, end_next;
    logic            jumped_reg, jumped_next;
    logic [HW-1:0]   hops_reg, hops_next;
    count_t          rc_reg, rc_next;
    count_t          qd_reg, qd_next;
    count_t          an_reg, an_next;
    logic            phase_q_reg, phase_q_next;
    logic [2:0]      k_reg, k_next;
    logic            found_reg, found_next;
    logic [31:0]     word_reg, word_next;
    logic            pend_reg;
    logic            ok_reg;

    offset_t           len_ext;
    offset_t           rd_off;
    logic              rd_req;
    logic              rd_in_range;
    logic [7:0]        rd_data;
    logic [31:0]       word_cap;
    offset_t           o2;
    logic [OFFSET_W:0] fix_end;
    logic [OFFSET_W:0] data_end;

    assign len_ext     = {{(OFFSET_W - LW){1'b0}}, len_reg};
    assign rd_in_range = rd_off < len_ext;
    assign rd_en       = rd_req;
    assign rd_addr     = rd_in_range ? rd_off[AW-1:0] : '0;
    // Reads beyond the loaded length return zero.
    assign rd_data     = ok_reg ? rd_q : 8'h00;
    assign word_cap    = {word_reg[23:0], rd_data};
    assign o2          = offset_reg + offset_t'(FIX_BYTES);
    assign fix_end     = {1'b0, offset_reg} + (OFFSET_W+1)'(FIX_BYTES);
    assign data_end    = {1'b0, o2} + (OFFSET_W+1)'(A_BYTES);

    assign busy        = (state_reg != W_IDLE);
    assign res.valid   = (state_reg == W_DONE);
    assign res.found   = found_reg;
    assign res.address = found_reg ? word_reg : 32'd0;

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        offset_next  = offset_reg;
        pos_next     = pos_reg;
        end_next     = end_reg;
        jumped_next  = jumped_reg;
        hops_next    = hops_reg;
        rc_next      = rc_reg;
        qd_next      = qd_reg;
        an_next      = an_reg;
        phase_q_next = phase_q_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        word_next    = pend_reg ? word_cap : word_reg;
        rd_req       = 1'b0;
        rd_off       = '0;

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    len_next   = start_len;
                    found_next = 1'b0;
                    k_next     = '0;
                    if (start_len < LW'(HDR_BYTES))
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        state_next = W_HDR;
                    end
                end
            end
            W_HDR:
            begin
                // Answer count bytes first, then the question count.
                case (k_reg)
                    3'd0:    rd_off = HDR_AN_HI;
                    3'd1:    rd_off = HDR_AN_LO;
                    3'd2:    rd_off = HDR_QD_HI;
                    default: rd_off = HDR_QD_LO;
                endcase
                rd_req = (k_reg < 3'd4);
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    an_next = word_cap[31:16];
                    qd_next = word_cap[15:0];
                    if (word_cap[31:16] == '0)
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        offset_next  = offset_t'(HDR_BYTES);
                        rc_next      = '0;
                        phase_q_next = 1'b1;
                        state_next   = W_REC;
                    end
                end
            end
            W_REC:
            begin
                if (phase_q_reg && rc_reg == qd_reg)
                begin
                    phase_q_next = 1'b0;
                    rc_next      = '0;
                end
                else if (offset_reg >= len_ext || (!phase_q_reg && rc_reg == an_reg))
                begin
                    // An offset past the end in the question section can only
                    // end with an empty answer walk, so it fails right here.
                    state_next = W_DONE;
                end
                else
                begin
                    pos_next    = offset_reg;
                    end_next    = '0;
                    jumped_next = 1'b0;
                    hops_next   = '0;
                    state_next  = W_NAME;
                end
            end
            W_NAME:
            begin
                if (pos_reg >= len_ext)
                begin
                    offset_next = jumped_reg ? end_reg : pos_reg;
                    state_next  = W_NEND;
                end
                else
                begin
                    rd_req     = 1'b1;
                    rd_off     = pos_reg;
                    state_next = W_NDEC;
                end
            end
            W_NDEC:
            begin
                if (rd_data == 8'h00)
                begin
                    offset_next = jumped_reg ? end_reg : (pos_reg + offset_t'(1));
                    state_next  = W_NEND;
                end
                else if ((rd_data & PTR_MASK) == PTR_MASK)
                begin
                    if (hops_reg >= HW'(MAX_POINTER_HOPS))
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        hops_next = hops_reg + HW'(1);
                        if (!jumped_reg)
                        begin
                            end_next    = pos_reg + offset_t'(2);
                            jumped_next = 1'b1;
                        end
                        rd_req     = 1'b1;
                        rd_off     = pos_reg + offset_t'(1);
                        state_next = W_PTR;
                    end
                end
                else
                begin
                    pos_next   = sat_add(pos_reg, count_t'(rd_data) + count_t'(1));
                    state_next = W_NAME;
                end
            end
            W_PTR:
            begin
                pos_next   = offset_t'({word_reg[5:0], rd_data});
                state_next = W_NAME;
            end
            W_NEND:
            begin
                k_next = '0;
                if (phase_q_reg)
                begin
                    offset_next = sat_add(offset_reg, count_t'(QTAIL_BYTES));
                    rc_next     = rc_reg + count_t'(1);
                    state_next  = W_REC;
                end
                else if (fix_end > {1'b0, len_ext})
                begin
                    state_next = W_DONE;
                end
                else
                begin
                    state_next = W_FIX;
                end
            end
            W_FIX:
            begin
                case (k_reg)
                    3'd0:    rd_off = offset_reg + FIX_TYPE_HI;
                    3'd1:    rd_off = offset_reg + FIX_TYPE_LO;
                    3'd2:    rd_off = offset_reg + FIX_RDLEN_HI;
                    default: rd_off = offset_reg + FIX_RDLEN_LO;
                endcase
                rd_req = (k_reg < 3'd4);
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    k_next = '0;
                    if (word_cap[31:16] == TYPE_A && word_cap[15:0] == A_RDLEN
                        && data_end <= {1'b0, len_ext})
                    begin
                        offset_next = o2;
                        state_next  = W_DATA;
                    end
                    else
                    begin
                        offset_next = sat_add(o2, word_cap[15:0]);
                        rc_next     = rc_reg + count_t'(1);
                        state_next  = W_REC;
                    end
                end
            end
            W_DATA:
            begin
                rd_off = offset_reg + offset_t'(k_reg);
                rd_req = (k_reg < 3'd4);
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    found_next = 1'b1;
                    state_next = W_DONE;
                end
            end
            W_DONE:
            begin
                if (res_ready)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= W_IDLE;
            len_reg     <= '0;
            offset_reg  <= '0;
            pos_reg     <= '0;
            end_reg     <= '0;
            jumped_reg  <= 1'b0;
            hops_reg    <= '0;
            rc_reg      <= '0;
            phase_q_reg <= 1'b0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            offset_reg  <= offset_next;
            pos_reg     <= pos_next;
            end_reg     <= end_next;
            jumped_reg  <= jumped_next;
            hops_reg    <= hops_next;
            rc_reg      <= rc_next;
            phase_q_reg <= phase_q_next;
            k_reg       <= k_next;
            found_reg   <= found_next;
            pend_reg    <= rd_req;
            ok_reg      <= rd_req && rd_in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg   <= qd_next;
        an_reg   <= an_next;
        word_reg <= word_next;
    end

endmodule

FILE: hdl/dra_check.sv
module dra_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] address,
    input logic        found
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(address) && $stable(found))
        else $error("result word changed while stalled");

    // A failed parse always reports a zero address.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> address == 32'd0)
        else $error("failed parse with a nonzero address");

    // The last word of a packet starts the parse, which stalls the input.
    a_parse_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> in_stall)
        else $error("input not stalled after the last word");

    // A new result only appears at the end of a parse.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a parse");

endmodule

bind dns_response_a_record_extract dra_check u_dra_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .address   (address),
    .found     (found)
);

FILE: tb/tb_dns_response_a_record_extract.sv
module tb_dns_response_a_record_extract;
    timeunit 1ns;
    timeprecision 1ps;

    import dra_pkg::*;

    // Clock, run length and settle time after the last result.
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 200;

    // The block is built with its default sizes, so the predictor uses the same ones.
    localparam int PACKET_BYTES = DEF_PACKET_BYTES;
    localparam int MAX_HOPS     = DEF_MAX_POINTER_HOPS;
    localparam int OFFSET_LIMIT = int'(OFFSET_MAX);

    // Record types used when building answers. The A type comes from the package.
    localparam int RTYPE_CNAME = 5;
    localparam int RTYPE_TXT   = 16;
    localparam int RTYPE_AAAA  = 28;
    localparam int CLASS_IN    = 1;

    // Pacing phases: percent of cycles the sender idles and the receiver stalls.
    localparam int PHASE_COUNT = 4;
    localparam int IDLE_BY_PHASE  [PHASE_COUNT] = '{0, 78, 0, 7};
    localparam int STALL_BY_PHASE [PHASE_COUNT] = '{0, 0, 78, 7};

    // Ways a generated response gets damaged before it is sent.
    typedef enum int {
        DMG_NONE,
        DMG_TRUNCATE,
        DMG_FLIP,
        DMG_SELF_LOOP,
        DMG_WILD_POINTER,
        DMG_NOISE
    } damage_t;

    // One predicted lookup result.
    typedef struct packed {
        logic [31:0] address;
        logic        found;
    } a_lookup_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] address;
    logic        found;

    dns_response_a_record_extract i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .address   (address),
        .found     (found)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shared test state.
    // ------------------------------------------------------------------

    // Lookups predicted for packets already accepted, oldest first.
    a_lookup_t expected_lookups[$];
    a_lookup_t oldest_lookup;
    int        error_count = 0;
    int        cycle_count = 0;

    // Pacing knobs, changed by the tests between phases.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // Cycles the receiver still has to hold off the output. A test loads it,
    // and the receiver process counts it down on its own.
    int hold_off_left = 0;

    // The response being assembled before it is streamed into the block.
    logic [7:0] frame[$];

    // ------------------------------------------------------------------
    // Predictor: a private copy of the packet memory and byte count, plus
    // the header, question and answer walk that picks the first A record.
    // ------------------------------------------------------------------

    logic [7:0] loaded_bytes[PACKET_BYTES];
    int         loaded_count = 0;

    // Anything at or past the loaded length reads as zero, so an entry left
    // over from an earlier packet never leaks into the walk.
    function automatic int loaded_byte(int idx);
        if (idx < loaded_count && idx < PACKET_BYTES)
            return int'(loaded_bytes[idx]);
        return 0;
    endfunction

    // Walk offsets saturate at the top of their 17-bit range.
    function automatic int offset_add(int a, int b);
        int sum;
        sum = a + b;
        return (sum > OFFSET_LIMIT) ? OFFSET_LIMIT : sum;
    endfunction

    // Returns the offset just past the name at start. Pointers are followed
    // only to find where the name ends; the name itself then ends two bytes
    // after the first pointer. Too many pointers in one name sets hop_fail.
    function automatic int name_end_offset(int start, output bit hop_fail);
        int pos;
        int name_end;
        int hops;
        int label;
        bit jumped;
        pos      = start;
        name_end = 0;
        hops     = 0;
        jumped   = 1'b0;
        hop_fail = 1'b0;
        while (pos < loaded_count) begin
            label = loaded_byte(pos);
            if (label == 0) begin
                if (!jumped)
                    name_end = pos + 1;
                break;
            end
            if ((label & int'(PTR_MASK)) == int'(PTR_MASK)) begin
                if (hops >= MAX_HOPS) begin
                    hop_fail = 1'b1;
                    return pos;
                end
                hops++;
                if (!jumped) begin
                    name_end = pos + 2;
                    jumped   = 1'b1;
                end
                pos = ((label & 'h3F) << 8) | loaded_byte(pos + 1);
                continue;
            end
            pos = offset_add(pos, label + 1);
        end
        // A name that runs off the end before any pointer leaves the offset where the walk stopped.
        return (jumped || name_end != 0) ? name_end : pos;
    endfunction

    // Parses the loaded packet; returns 1 with the address when an A record
    // with four data bytes inside the packet is found.
    function automatic bit find_a_record(output logic [31:0] addr);
        int len;
        int answers;
        int questions;
        int walk;
        int fixed_at;
        int rtype;
        int rdlen;
        bit hop_fail;
        addr = '0;
        len  = loaded_count;
        if (len < HDR_BYTES)
            return 1'b0;
        answers = (loaded_byte(int'(HDR_AN_HI)) << 8) | loaded_byte(int'(HDR_AN_LO));
        if (answers == 0)
            return 1'b0;
        questions = (loaded_byte(int'(HDR_QD_HI)) << 8) | loaded_byte(int'(HDR_QD_LO));
        walk = HDR_BYTES;

        for (int n = 0; n < questions; n++) begin
            walk = name_end_offset(walk, hop_fail);
            if (hop_fail)
                return 1'b0;
            walk = offset_add(walk, QTAIL_BYTES);
        end

        for (int n = 0; n < answers && walk < len; n++) begin
            walk = name_end_offset(walk, hop_fail);
            if (hop_fail)
                return 1'b0;
            fixed_at = walk;
            // An answer whose fixed part is cut off ends the parse.
            if (fixed_at + FIX_BYTES > len)
                return 1'b0;
            rtype = (loaded_byte(fixed_at + int'(FIX_TYPE_HI)) << 8)
                  | loaded_byte(fixed_at + int'(FIX_TYPE_LO));
            rdlen = (loaded_byte(fixed_at + int'(FIX_RDLEN_HI)) << 8)
                  | loaded_byte(fixed_at + int'(FIX_RDLEN_LO));
            walk = fixed_at + FIX_BYTES;
            if (rtype == int'(TYPE_A) && rdlen == int'(A_RDLEN) && walk + A_BYTES <= len) begin
                addr = (loaded_byte(walk) << 24) | (loaded_byte(walk + 1) << 16)
                     | (loaded_byte(walk + 2) << 8) | loaded_byte(walk + 3);
                return 1'b1;
            end
            walk = offset_add(walk, rdlen);
        end
        return 1'b0;
    endfunction

    // Applies one accepted word to the predictor. The last word of a packet
    // produces one expected lookup and clears the byte count.
    function automatic void load_packet_byte(logic [7:0] value, logic last);
        a_lookup_t lookup;
        logic [31:0] addr;
        if (loaded_count < PACKET_BYTES) begin
            loaded_bytes[loaded_count] = value;
            loaded_count++;
        end
        if (last) begin
            lookup.found   = find_a_record(addr);
            lookup.address = addr;
            expected_lookups.push_back(lookup);
            loaded_count = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sending side. Inputs change on the falling edge; acceptance is judged
    // from in_stall as it stood at the rising edge.
    // ------------------------------------------------------------------

    task automatic send_word(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom_range(255));
            last_byte <= 1'($urandom_range(1));
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        load_packet_byte(value, last);
    endtask

    // Streams the assembled frame, marking its final byte as the last word.
    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_word(frame[i], i == frame.size() - 1);
    endtask

    // Drops valid once the stimulus is done and waits for the outstanding lookups.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_pacing(int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Receiving side: random stalls, or a long hold-off when one is loaded.
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (hold_off_left > 0) begin
            out_stall     <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: result with nothing expected, address %h found %b",
                         $time, address, found);
                error_count++;
            end else begin
                oldest_lookup = expected_lookups.pop_front();
                if (address !== oldest_lookup.address) begin
                    $display("%0t: address mismatch, expected %h, actual %h",
                             $time, oldest_lookup.address, address);
                    error_count++;
                end
                if (found !== oldest_lookup.found) begin
                    $display("%0t: found mismatch, expected %b, actual %b",
                             $time, oldest_lookup.found, found);
                    error_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response builders.
    // ------------------------------------------------------------------

    function automatic void put_byte(int value);
        frame.push_back(8'(value));
    endfunction

    function automatic void put_word16(int value);
        put_byte(value >> 8);
        put_byte(value);
    endfunction

    function automatic void put_random(int count);
        repeat (count) put_byte($urandom_range(255));
    endfunction

    // Pointer to the given offset, with the two top bits marking it as one.
    function automatic void put_pointer(int target);
        put_byte(int'(PTR_MASK) | ((target >> 8) & 'h3F));
        put_byte(target);
    endfunction

    // A name: root, a bare pointer to the first question, or labels that end
    // either in the root label or in a pointer. The first question name must
    // not be a bare pointer to itself, so pointers can be turned off.
    function automatic void put_name(bit allow_pointer);
        int piece_bytes;
        case ($urandom_range(3))
            0: put_byte(0);
            1: begin
                if (allow_pointer)
                    put_pointer(HDR_BYTES);
                else
                    put_byte(0);
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    piece_bytes = $urandom_range(1, 10);
                    put_byte(piece_bytes);
                    put_random(piece_bytes);
                end
                if (allow_pointer && $urandom_range(1))
                    put_pointer(HDR_BYTES);
                else
                    put_byte(0);
            end
        endcase
    endfunction

    // A plausible response: header, a few questions, a few answers with a
    // mix of record types. A records mostly carry four data bytes.
    function automatic void build_response();
        int questions;
        int answers;
        int pick;
        int rtype;
        int rdlen;
        frame.delete();
        questions = $urandom_range(0, 2);
        answers   = $urandom_range(1, 3);
        put_word16($urandom_range(16'hFFFF));
        put_word16($urandom_range(16'hFFFF));
        put_word16(questions);
        put_word16(answers);
        put_word16($urandom_range(0, 3));
        put_word16($urandom_range(0, 3));
        for (int q = 0; q < questions; q++) begin
            put_name(q > 0);
            put_word16($urandom_range(1) ? int'(TYPE_A) : RTYPE_AAAA);
            put_word16(CLASS_IN);
        end
        for (int a = 0; a < answers; a++) begin
            put_name(questions > 0);
            pick = $urandom_range(9);
            if (pick < 5)
                rtype = int'(TYPE_A);
            else if (pick == 5)
                rtype = RTYPE_CNAME;
            else if (pick == 6)
                rtype = RTYPE_AAAA;
            else if (pick == 7)
                rtype = RTYPE_TXT;
            else
                rtype = $urandom_range(16'hFFFF);
            if (rtype == int'(TYPE_A))
                rdlen = ($urandom_range(5) != 0) ? int'(A_RDLEN) : $urandom_range(0, 8);
            else if (rtype == RTYPE_AAAA)
                rdlen = ($urandom_range(3) != 0) ? 16 : $urandom_range(0, 20);
            else
                rdlen = $urandom_range(0, 12);
            put_word16(rtype);
            put_word16(CLASS_IN);
            put_random(4);
            put_word16(rdlen);
            put_random(rdlen);
        end
    endfunction

    // Breaks the frame in one of several ways. The question count's high
    // byte is left alone so no packet asks for tens of thousands of questions;
    // that case is covered once on purpose.
    function automatic void damage_frame(bit always_damage);
        damage_t kind;
        int      pick;
        int      idx;
        pick = always_damage ? $urandom_range(5, 9) : $urandom_range(9);
        kind = (pick < 5) ? DMG_NONE : damage_t'(pick - 4);
        case (kind)
            DMG_TRUNCATE: begin
                idx = $urandom_range(1, frame.size() - 1);
                while (frame.size() > idx)
                    void'(frame.pop_back());
            end
            DMG_FLIP: begin
                idx = $urandom_range(0, frame.size() - 1);
                if (idx != int'(HDR_QD_HI))
                    frame[idx] = 8'($urandom_range(255));
            end
            DMG_SELF_LOOP: begin
                // The name at the first record points at itself.
                if (frame.size() > HDR_BYTES + 1) begin
                    frame[HDR_BYTES]     = PTR_MASK;
                    frame[HDR_BYTES + 1] = 8'(HDR_BYTES);
                end
            end
            DMG_WILD_POINTER: begin
                // A pointer anywhere, often aiming past the loaded bytes.
                if (frame.size() > HDR_BYTES + 1) begin
                    idx = $urandom_range(HDR_BYTES, frame.size() - 2);
                    frame[idx]     = PTR_MASK | 8'($urandom_range('h3F));
                    frame[idx + 1] = 8'($urandom_range(255));
                end
            end
            DMG_NOISE: begin
                frame.delete();
                put_random($urandom_range(1, 40));
                if (frame.size() > int'(HDR_QD_HI))
                    frame[HDR_QD_HI] = 8'h00;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Packets that never reach the answers: a one-word packet, a bare header
    // with no answers, and a bare header claiming every possible question,
    // which drives the walk offset into saturation.
    task automatic test_short_headers();
        set_pacing(0, 0);
        frame.delete();
        put_byte(8'hFF);
        send_frame();

        frame.delete();
        put_word16($urandom_range(16'hFFFF));
        put_word16(16'hFFFF);
        put_word16(1);
        put_word16(0);
        put_word16(0);
        put_word16(16'hFFFF);
        send_frame();

        frame.delete();
        put_word16(0);
        put_word16(0);
        put_word16(16'hFFFF);
        put_word16(1);
        put_word16(0);
        put_word16(0);
        send_frame();
    endtask

    // Responses with random content, about half of them damaged, under each pacing phase.
    task automatic test_well_formed();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_pacing(IDLE_BY_PHASE[phase], STALL_BY_PHASE[phase]);
            repeat (2) begin
                build_response();
                damage_frame(1'b0);
                send_frame();
            end
        end
    endtask

    // Truncated, corrupted, looping and pure-noise packets.
    task automatic test_damaged();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_pacing(IDLE_BY_PHASE[phase], STALL_BY_PHASE[phase]);
            build_response();
            damage_frame(1'b1);
            send_frame();
        end
    endtask

    // One question whose name is a chain of pointers, placed after a single
    // A answer. The chain length straddles the hop limit, so the answer is
    // found when the chain is just short enough and lost one hop later.
    task automatic test_pointer_chains();
        int hops;
        int chain_at;
        set_pacing(7, 7);
        for (int round = 0; round < 4; round++) begin
            case (round)
                0: hops = 1;
                1: hops = MAX_HOPS;
                2: hops = MAX_HOPS + 1;
                default: hops = $urandom_range(2, MAX_HOPS + 1);
            endcase
            // Header, pointer name, question tail, then an answer with a root
            // name: the chain starts right after it.
            chain_at = HDR_BYTES + 2 + QTAIL_BYTES + 1 + FIX_BYTES + A_BYTES;
            frame.delete();
            put_word16($urandom_range(16'hFFFF));
            put_word16($urandom_range(16'hFFFF));
            put_word16(1);
            put_word16(1);
            put_word16(0);
            put_word16(0);
            put_pointer(chain_at);
            put_word16(int'(TYPE_A));
            put_word16(CLASS_IN);
            put_byte(0);
            put_word16(int'(TYPE_A));
            put_word16(CLASS_IN);
            put_random(4);
            put_word16(int'(A_RDLEN));
            put_random(A_BYTES);
            for (int i = 0; i < hops - 1; i++)
                put_pointer(chain_at + 2 * (i + 1));
            put_byte(0);
            send_frame();
        end
    endtask

    // A response longer than the packet memory: a long text record pushes the
    // A record toward or past the last stored byte, and filler runs beyond it.
    task automatic test_oversize();
        int text_len;
        int total;
        set_pacing(0, 0);
        frame.delete();
        put_word16($urandom_range(16'hFFFF));
        put_word16($urandom_range(16'hFFFF));
        put_word16(1);
        put_word16(2);
        put_word16(0);
        put_word16(0);
        put_name(1'b0);
        put_word16(int'(TYPE_A));
        put_word16(CLASS_IN);
        text_len = $urandom_range(440, 500);
        put_pointer(HDR_BYTES);
        put_word16(RTYPE_TXT);
        put_word16(CLASS_IN);
        put_random(4);
        put_word16(text_len);
        put_random(text_len);
        put_pointer(HDR_BYTES);
        put_word16(int'(TYPE_A));
        put_word16(CLASS_IN);
        put_random(4);
        put_word16(int'(A_RDLEN));
        put_random(A_BYTES);
        total = $urandom_range(PACKET_BYTES + 1, PACKET_BYTES + 40);
        if (frame.size() < total)
            put_random(total - frame.size());
        send_frame();
    endtask

    // The receiver holds the output for a long stretch while packets keep
    // coming, so a finished result backs up and the block stalls its input.
    task automatic test_output_hold_off();
        set_pacing(0, 0);
        hold_off_left = 400;
        repeat (3) begin
            build_response();
            send_frame();
        end
    endtask

    // The sender waits for every outstanding lookup before the next packet.
    task automatic test_drain_pause();
        set_pacing(0, 7);
        repeat (2) begin
            build_response();
            send_frame();
            wait_for_drain();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_headers();
        test_well_formed();
        test_damaged();
        test_pointer_chains();
        test_oversize();
        test_output_hold_off();
        test_drain_pause();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
